// ===== sv/erdu_pkg.sv =====
// Shared types, constants and codes for the echo range to duty and ASCII unit.
`default_nettype none

package erdu_pkg;

    // Field widths
    localparam int TicksW = 16;
    localparam int DistW  = 8;
    localparam int ByteW  = 8;
    localparam int IdxW   = 8;
    localparam int DataW  = 16;
    localparam int ProdW  = 25;   // ticks * 343
    localparam int QuoW   = 37;   // (prod >> 3) * reciprocal of 625

    // Distance conversion: dist = floor(ticks * 343 / 5000)
    // done as floor(floor(p / 8) / 625) with a reciprocal multiply.
    localparam logic [8:0]       Mul343     = 9'd343;
    localparam logic [18:0]      Recip625   = 19'd429497;  // ceil(2^28 / 625)
    localparam logic [ProdW-1:0] SatProd    = 25'd1280000; // 256 * 5000
    localparam logic [DistW-1:0] DistMax    = 8'd255;

    // Characters
    localparam logic [ByteW-1:0] AsciiZero = 8'd48;
    localparam logic [ByteW-1:0] AsciiNine = 8'd57;
    localparam logic [ByteW-1:0] AsciiNl   = 8'd10;

    // Queue between front and back
    localparam int QDepth = 4;
    localparam int QAw    = $clog2(QDepth);
    localparam int CntW   = $clog2(QDepth + 1);

    // Register reset values
    localparam logic [7:0]  NearRst  = 8'd15;
    localparam logic [7:0]  FarRst   = 8'd40;
    localparam logic [7:0]  DpcRst   = 8'd10;
    localparam logic [15:0] LimitRst = 16'd3700;

    typedef enum logic [IdxW-1:0] {
        CFG_NEAR  = 8'd0,
        CFG_FAR   = 8'd1,
        CFG_DPC   = 8'd2,
        CFG_LIMIT = 8'd3
    } cfg_idx_t;

    // Character slot within one run
    typedef enum logic [1:0] {
        SLOT_HUND = 2'd0,
        SLOT_TENS = 2'd1,
        SLOT_ONES = 2'd2,
        SLOT_NL   = 2'd3
    } slot_t;

    typedef struct packed {
        logic [7:0]  near_cm;
        logic [7:0]  far_cm;
        logic [7:0]  duty_per_cm;
        logic [15:0] echo_limit;
    } cfg_t;

    // Classified item as held in the queue
    typedef struct packed {
        logic [7:0] duty;
        logic       oob;
        logic [1:0] hund;
        logic [3:0] tens;
        logic [3:0] ones;
        slot_t      start;
    } rec_t;

endpackage

`default_nettype wire

// ===== sv/echo_range_to_duty_and_ascii_unit.sv =====
// Path: an echo passes the front stages, the queue and the output register to the result ports.
// Throughput: one push beat per cycle while credit remains; the back end drains 2 to 4
// characters per echo (digits plus newline), one per cycle while the result side pops.
// The back end's single output register limits the sustained echo rate.
// Reset (rst_n low, asynchronous): pipeline, queue and output emptied, registers to defaults.
`default_nettype none

module echo_range_to_duty_and_ascii_unit import erdu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // echo input
    input  wire logic              push,
    output logic                   full,
    input  wire logic [TicksW-1:0] echo_ticks,
    // character results
    output logic                   empty,
    input  wire logic              pop,
    output logic [7:0]             duty,
    output logic                   out_of_band,
    output logic [ByteW-1:0]       char_byte,
    output logic                   last,
    // register writes
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [IdxW-1:0]   cfg_index,
    input  wire logic [DataW-1:0]  cfg_data
);

    // Register file. Writes are always taken; unknown indexes are dropped.
    cfg_t            cfg_reg, cfg_next;
    logic            cfg_we;

    // Credit count: items in the front pipeline plus records in the queue.
    // Holding it at the queue depth means the pipeline never has to stall.
    logic [CntW-1:0] credit_reg, credit_next;

    logic            in_take;
    logic            rec_valid;
    rec_t            rec;
    logic            head_valid;
    rec_t            head_rec;
    logic            head_pop;
    logic            out_valid;
    logic            out_take;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NEAR:  cfg_next.near_cm     = cfg_data[7:0];
                CFG_FAR:   cfg_next.far_cm      = cfg_data[7:0];
                CFG_DPC:   cfg_next.duty_per_cm = cfg_data[7:0];
                CFG_LIMIT: cfg_next.echo_limit  = cfg_data;
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.near_cm     <= NearRst;
            cfg_reg.far_cm      <= FarRst;
            cfg_reg.duty_per_cm <= DpcRst;
            cfg_reg.echo_limit  <= LimitRst;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Input beat taken while credit is left
    assign full    = (credit_reg == CntW'(QDepth));
    assign in_take = push && !full;

    // retire a credit when the newline of a record leaves the queue
    assign credit_next = credit_reg + CntW'(in_take) - CntW'(head_pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // Front: three stage conversion and classification
    erdu_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_take    (in_take),
        .echo_ticks (echo_ticks),
        .cfg        (cfg_reg),
        .rec_valid  (rec_valid),
        .rec        (rec)
    );

    // Records wait here until the back end has spelt them out
    erdu_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (rec_valid),
        .wr_rec     (rec),
        .rd_en      (head_pop),
        .head_valid (head_valid),
        .head_rec   (head_rec)
    );

    // Back: one character per beat through the output register
    assign out_take = pop && !empty;

    erdu_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_rec   (head_rec),
        .head_pop   (head_pop),
        .out_pop    (out_take),
        .out_valid  (out_valid),
        .out_duty   (duty),
        .out_oob    (out_of_band),
        .out_char   (char_byte),
        .out_last   (last)
    );

    assign empty = !out_valid;

    // Checks

    // credit never runs past the queue depth
    a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
        credit_reg <= CntW'(QDepth))
        else $error("credit count above queue depth");

    // the queue only pops when a record is present
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        head_pop |-> head_valid)
        else $error("queue popped while empty");

    // a closing beat always carries the newline
    a_last_nl: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && last) |-> (char_byte == AsciiNl))
        else $error("last beat is not a newline");

    // other beats carry a decimal digit
    a_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !last) |-> ((char_byte >= AsciiZero) && (char_byte <= AsciiNine)))
        else $error("digit beat out of range");

endmodule

`default_nettype wire

// ===== sv/erdu_front.sv =====
// Front pipeline: ticks to distance, duty, flag and decimal digits.
`default_nettype none

module erdu_front import erdu_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_take,
    input  wire logic [TicksW-1:0] echo_ticks,
    input  wire cfg_t              cfg,
    output logic                   rec_valid,
    output rec_t                   rec
);

    logic              s1_valid_reg, s1_valid_next;
    logic [ProdW-1:0]  s1_prod_reg, s1_prod_next;
    logic              s1_lim_reg, s1_lim_next;
    logic              s2_valid_reg, s2_valid_next;
    logic [DistW-1:0]  s2_dist_reg, s2_dist_next;
    logic              s3_valid_reg, s3_valid_next;
    rec_t              s3_rec_reg, s3_rec_next;

    logic [QuoW-1:0]   quo;
    logic              below;
    logic              above;
    logic [DistW-1:0]  diff;
    logic [15:0]       dprod;
    logic [1:0]        hund;
    logic [7:0]        rem8;
    logic [6:0]        rem;
    logic [14:0]       tprod;
    logic [3:0]        tens;
    logic [7:0]        ones8;

    // stage 1: ticks * 343, limit test
    always_comb
    begin
        s1_valid_next = in_take;
        s1_prod_next  = ProdW'(echo_ticks) * ProdW'(Mul343);
        s1_lim_next   = (echo_ticks >= cfg.echo_limit);
    end

    // stage 2: divide by 5000; anything past 255 cm is clamped anyway
    always_comb
    begin
        quo           = QuoW'(s1_prod_reg[20:3]) * QuoW'(Recip625);
        s2_valid_next = s1_valid_reg;
        if (s1_lim_reg || (s1_prod_reg >= SatProd))
        begin
            s2_dist_next = DistMax;
        end
        else
        begin
            s2_dist_next = quo[35:28];
        end
    end

    // stage 3: duty, flag, digits
    always_comb
    begin
        below = (s2_dist_reg < cfg.near_cm);
        above = (s2_dist_reg > cfg.far_cm);
        diff  = s2_dist_reg - cfg.near_cm;
        dprod = 16'(diff) * 16'(cfg.duty_per_cm);

        if (s2_dist_reg >= 8'd200)
        begin
            hund = 2'd2;
        end
        else if (s2_dist_reg >= 8'd100)
        begin
            hund = 2'd1;
        end
        else
        begin
            hund = 2'd0;
        end
        rem8  = s2_dist_reg - 8'(hund) * 8'd100;
        rem   = rem8[6:0];
        tprod = 15'(rem) * 15'd205;       // x*205 >> 11 == x/10 for x < 100
        tens  = tprod[14:11];
        ones8 = 8'(rem) - 8'(tens) * 8'd10;

        s3_valid_next    = s2_valid_reg;
        s3_rec_next.hund = hund;
        s3_rec_next.tens = tens;
        s3_rec_next.ones = ones8[3:0];
        if (hund != 2'd0)
        begin
            s3_rec_next.start = SLOT_HUND;
        end
        else if (tens != 4'd0)
        begin
            s3_rec_next.start = SLOT_TENS;
        end
        else
        begin
            s3_rec_next.start = SLOT_ONES;
        end

        if (below)
        begin
            s3_rec_next.duty = 8'd0;
            s3_rec_next.oob  = 1'b1;
        end
        else if (above)
        begin
            s3_rec_next.duty = 8'd255;
            s3_rec_next.oob  = 1'b1;
        end
        else
        begin
            s3_rec_next.duty = (dprod > 16'd255) ? 8'd255 : dprod[7:0];
            s3_rec_next.oob  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            s3_valid_reg <= s3_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_prod_reg <= s1_prod_next;
        s1_lim_reg  <= s1_lim_next;
        s2_dist_reg <= s2_dist_next;
        s3_rec_reg  <= s3_rec_next;
    end

    assign rec_valid = s3_valid_reg;
    assign rec       = s3_rec_reg;

endmodule

`default_nettype wire

// ===== sv/erdu_queue.sv =====
// Short record queue between front and back.
`default_nettype none

module erdu_queue import erdu_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire rec_t wr_rec,
    input  wire logic rd_en,
    output logic      head_valid,
    output rec_t      head_rec
);

    rec_t             mem_reg [QDepth];
    logic [QAw-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QAw-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]  count_reg, count_next;

    // space is guaranteed upstream by the credit count
    always_comb
    begin
        wr_ptr_next = wr_en ? wr_ptr_reg + QAw'(1'b1) : wr_ptr_reg;
        rd_ptr_next = rd_en ? rd_ptr_reg + QAw'(1'b1) : rd_ptr_reg;
        count_next  = count_reg + CntW'(wr_en) - CntW'(rd_en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_rec   = mem_reg[rd_ptr_reg];

endmodule

`default_nettype wire

// ===== sv/erdu_back.sv =====
// Back end: walks each record out as characters into the output register.
`default_nettype none

module erdu_back import erdu_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        head_valid,
    input  wire rec_t        head_rec,
    output logic             head_pop,
    input  wire logic        out_pop,
    output logic             out_valid,
    output logic [7:0]       out_duty,
    output logic             out_oob,
    output logic [ByteW-1:0] out_char,
    output logic             out_last
);

    logic             mid_reg, mid_next;
    slot_t            slot_reg, slot_next;
    logic             oval_reg, oval_next;
    logic [7:0]       duty_reg, duty_next;
    logic             oob_reg, oob_next;
    logic [ByteW-1:0] char_reg, char_next;
    logic             last_reg, last_next;

    slot_t            cur_slot;
    logic             load;

    always_comb
    begin
        cur_slot = mid_reg ? slot_reg : head_rec.start;
        load     = head_valid && (!oval_reg || out_pop);
        head_pop = load && (cur_slot == SLOT_NL);
    end

    always_comb
    begin
        mid_next  = mid_reg;
        slot_next = slot_reg;
        if (load)
        begin
            mid_next  = (cur_slot != SLOT_NL);
            slot_next = slot_t'(cur_slot + 2'd1);
        end

        if (load)
        begin
            oval_next = 1'b1;
        end
        else if (out_pop)
        begin
            oval_next = 1'b0;
        end
        else
        begin
            oval_next = oval_reg;
        end
    end

    always_comb
    begin
        duty_next = load ? head_rec.duty : duty_reg;
        oob_next  = load ? head_rec.oob : oob_reg;
        last_next = load ? (cur_slot == SLOT_NL) : last_reg;
        char_next = char_reg;
        if (load)
        begin
            case (cur_slot)
                SLOT_HUND: char_next = AsciiZero + ByteW'(head_rec.hund);
                SLOT_TENS: char_next = AsciiZero + ByteW'(head_rec.tens);
                SLOT_ONES: char_next = AsciiZero + ByteW'(head_rec.ones);
                SLOT_NL:   char_next = AsciiNl;
                default:   char_next = AsciiNl;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg  <= 1'b0;
            slot_reg <= SLOT_HUND;
            oval_reg <= 1'b0;
        end
        else
        begin
            mid_reg  <= mid_next;
            slot_reg <= slot_next;
            oval_reg <= oval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        duty_reg <= duty_next;
        oob_reg  <= oob_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid = oval_reg;
    assign out_duty  = duty_reg;
    assign out_oob   = oob_reg;
    assign out_char  = char_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire
